FILE: sv/vuwe_pkg.sv
// vuwe_pkg: request and write types, register block, controller/datapath
// signal groups and code constants for the vector unpack write engine
// no dependencies

package vuwe_pkg;

	localparam int ADDR_BITS = 10;

	// request commands
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_ROW  = 2'd1;
	localparam logic [1:0] CMD_COL  = 2'd2;
	localparam logic [1:0] CMD_ADDR = 2'd3;

	// element width codes
	localparam logic [1:0] WC_32  = 2'd0;
	localparam logic [1:0] WC_16  = 2'd1;
	localparam logic [1:0] WC_8   = 2'd2;
	localparam logic [1:0] WC_BAD = 2'd3;

	// add modes
	localparam logic [1:0] ADD_NONE = 2'd0;
	localparam logic [1:0] ADD_ROW  = 2'd1;
	localparam logic [1:0] ADD_DIFF = 2'd2;

	// register indexes
	localparam logic [2:0] REG_FORMAT = 3'd0;
	localparam logic [2:0] REG_ADD    = 3'd1;
	localparam logic [2:0] REG_WL     = 3'd2;
	localparam logic [2:0] REG_CL     = 3'd3;
	localparam logic [2:0] REG_UNS    = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] comp_x;
		logic [31:0] comp_y;
		logic [31:0] comp_z;
		logic [31:0] comp_w;
		logic [9:0]  start_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] write_address;
		logic [31:0]          word_x;
		logic [31:0]          word_y;
		logic [31:0]          word_z;
		logic [31:0]          word_w;
		logic [3:0]           lane_enable;
		logic                 is_fill;
		logic                 last;
	} wr_t;

	typedef struct packed {
		logic [3:0] unpack_format;
		logic [1:0] add_mode;
		logic [5:0] write_length;
		logic [5:0] cycle_length;
		logic       unsigned_elements;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic fill;
		logic fill_last;
	} ctl_t;

	typedef struct packed {
		logic       item_valid;
		logic       item_write;
		logic       out_free;
		logic [5:0] fill_num;
	} stat_t;

endpackage

FILE: sv/vuwe_ctrl.sv
// vuwe_ctrl: controller state machine, takes requests and sequences fill writes
// depends on vuwe_pkg

module vuwe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  vuwe_pkg::stat_t stat,
	output vuwe_pkg::ctl_t  ctl
);
	import vuwe_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_FILL = 2'b10
	} state_t;

	state_t     state_q;
	logic [5:0] fill_left_q;

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				if (stat.item_valid && (stat.out_free || !stat.item_write)) begin
					ctl.take = 1'b1;
				end
			end
			ST_FILL: begin
				if (stat.out_free) begin
					ctl.fill      = 1'b1;
					ctl.fill_last = (fill_left_q == 6'd1);
				end
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_left_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.take && stat.item_write && stat.fill_num != 6'd0) begin
						state_q     <= ST_FILL;
						fill_left_q <= stat.fill_num;
					end
				end
				ST_FILL: begin
					if (ctl.fill) begin
						fill_left_q <= fill_left_q - 6'd1;
						if (ctl.fill_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> fill_left_q != 6'd0)
		else $error("fill state with no fill writes left");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |-> state_q == ST_IDLE)
		else $error("request taken during fill run");

	a_fill_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fill && ctl.fill_last) |=> state_q == ST_IDLE)
		else $error("fill run did not end after last fill write");

endmodule

FILE: sv/vuwe_dp.sv
// vuwe_dp: request register, unpack and row add, row/column/address state,
// output write register
// depends on vuwe_pkg

module vuwe_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  vuwe_pkg::req_t  req,
	output logic            wr_valid,
	input  logic            wr_ready,
	output vuwe_pkg::wr_t   wr,
	input  vuwe_pkg::cfg_t  cfg,
	input  vuwe_pkg::ctl_t  ctl,
	output vuwe_pkg::stat_t stat
);
	import vuwe_pkg::*;

	function automatic logic [31:0] widen(input logic [31:0] raw, input logic [1:0] wcode,
			input logic uns);
		logic [31:0] v;
		v = raw;
		if (wcode == WC_16) begin
			v = {{16{raw[15] & ~uns}}, raw[15:0]};
		end else if (wcode == WC_8) begin
			v = {{24{raw[7] & ~uns}}, raw[7:0]};
		end
		return v;
	endfunction

	req_t                 item_s1;
	logic                 item_valid_s1;
	logic [3:0][31:0]     raw_c;
	logic [3:0][31:0]     ext;
	logic [3:0][31:0]     sum;
	logic [3:0]           en;
	logic [1:0]           wcode;
	logic [1:0]           ncm1;
	logic                 add_en;
	logic                 is_write;
	logic [6:0]           cnt;
	logic                 fill_mode;
	logic                 blk_end;
	logic [5:0]           fill_num;
	logic [5:0]           wib_next;
	logic [5:0]           jump;
	logic [ADDR_BITS-1:0] addr_after;
	logic [3:0][31:0]     row_q;
	logic [3:0][31:0]     col_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [5:0]           wib_q;
	logic                 wr_valid_q;
	wr_t                  wr_q;

	// request register
	assign req_ready = !item_valid_s1 || ctl.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			item_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

	// unpack and row add
	assign raw_c    = {item_s1.comp_w, item_s1.comp_z, item_s1.comp_y, item_s1.comp_x};
	assign wcode    = cfg.unpack_format[1:0];
	assign ncm1     = cfg.unpack_format[3:2];
	assign add_en   = (cfg.add_mode == ADD_ROW) || (cfg.add_mode == ADD_DIFF);
	assign is_write = (item_s1.cmd == CMD_DATA) && (wcode != WC_BAD);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (ncm1 == 2'd0) begin
				ext[i] = widen(raw_c[0], wcode, cfg.unsigned_elements);
				en[i]  = 1'b1;
			end else begin
				en[i]  = (2'(i) <= ncm1);
				ext[i] = en[i] ? widen(raw_c[i], wcode, cfg.unsigned_elements) : 32'd0;
			end
			sum[i] = (add_en && en[i]) ? ext[i] + row_q[i] : ext[i];
		end
	end

	// block rule
	assign cnt        = {1'b0, wib_q} + 7'd1;
	assign fill_mode  = cfg.cycle_length < cfg.write_length;
	assign blk_end    = fill_mode ? (cnt >= {1'b0, cfg.cycle_length})
	                              : (cnt >= {1'b0, cfg.write_length});
	assign fill_num   = (fill_mode && blk_end) ? cfg.write_length - cfg.cycle_length : 6'd0;
	assign wib_next   = blk_end ? 6'd0 : cnt[5:0];
	assign jump       = (!fill_mode && blk_end) ? cfg.cycle_length - cfg.write_length : 6'd0;
	assign addr_after = addr_q + ADDR_BITS'(1) + {{(ADDR_BITS-6){1'b0}}, jump};

	assign stat.item_valid = item_valid_s1;
	assign stat.item_write = is_write;
	assign stat.out_free   = !wr_valid_q || wr_ready;
	assign stat.fill_num   = fill_num;

	// state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			addr_q <= '0;
			wib_q  <= '0;
		end else if (ctl.take) begin
			case (item_s1.cmd)
				CMD_ROW: begin
					row_q <= raw_c;
				end
				CMD_COL: begin
					col_q <= raw_c;
				end
				CMD_ADDR: begin
					addr_q <= ADDR_BITS'(item_s1.start_address);
					wib_q  <= '0;
				end
				CMD_DATA: begin
					if (is_write) begin
						addr_q <= addr_after;
						wib_q  <= wib_next;
						if (cfg.add_mode == ADD_DIFF) begin
							for (int i = 0; i < 4; i++) begin
								if (en[i]) begin
									row_q[i] <= sum[i];
								end
							end
						end
					end
				end
				default: begin
					wib_q <= wib_q;
				end
			endcase
		end else if (ctl.fill) begin
			addr_q <= addr_q + ADDR_BITS'(1);
		end
	end

	// output write register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if ((ctl.take && is_write) || ctl.fill) begin
			wr_valid_q <= 1'b1;
		end else if (wr_ready) begin
			wr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && is_write) begin
			wr_q.write_address <= addr_q;
			wr_q.word_x        <= sum[0];
			wr_q.word_y        <= sum[1];
			wr_q.word_z        <= sum[2];
			wr_q.word_w        <= sum[3];
			wr_q.lane_enable   <= en;
			wr_q.is_fill       <= 1'b0;
			wr_q.last          <= (fill_num == 6'd0);
		end else if (ctl.fill) begin
			wr_q.write_address <= addr_q;
			wr_q.word_x        <= col_q[0];
			wr_q.word_y        <= col_q[1];
			wr_q.word_z        <= col_q[2];
			wr_q.word_w        <= col_q[3];
			wr_q.lane_enable   <= 4'hf;
			wr_q.is_fill       <= 1'b1;
			wr_q.last          <= ctl.fill_last;
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid_q && !wr_ready) |-> !((ctl.take && is_write) || ctl.fill))
		else $error("pending write overwritten");

	a_fill_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill |=> addr_q == $past(addr_q) + ADDR_BITS'(1))
		else $error("fill write did not advance address");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take |-> item_valid_s1)
		else $error("request taken from empty register");

endmodule

FILE: sv/vector_unpack_write_engine.sv
// vector_unpack_write_engine: top level, APB register block, controller and datapath
// depends on vuwe_pkg, vuwe_ctrl, vuwe_dp
//
// channel  | handshake            | payload
// req      | req_valid/req_ready  | vuwe_pkg::req_t: command, four components, start address
// wr       | wr_valid/wr_ready    | vuwe_pkg::wr_t: address, four lanes, enables, fill, last
// apb      | psel/penable/pready  | paddr, pwdata, prdata: five registers at 4*i
//
// a request is held in the request register until the controller takes it
// a data request that ends a block in fill mode adds write_length - cycle_length fill
// writes, during which no request is taken; else one request per cycle unless wr stalls
// a stalled wr channel holds the write register and backs up into the request register
// reset clears registers, row, column, address and block count; no clearing pass

module vector_unpack_write_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  vuwe_pkg::req_t req,
	output logic           wr_valid,
	input  logic           wr_ready,
	output vuwe_pkg::wr_t  wr,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import vuwe_pkg::*;

	cfg_t       cfg_q;
	ctl_t       ctl;
	stat_t      stat;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_FORMAT: cfg_q.unpack_format     <= pwdata[3:0];
				REG_ADD:    cfg_q.add_mode          <= pwdata[1:0];
				REG_WL:     cfg_q.write_length      <= pwdata[5:0];
				REG_CL:     cfg_q.cycle_length      <= pwdata[5:0];
				REG_UNS:    cfg_q.unsigned_elements <= pwdata[0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FORMAT: prdata = {28'd0, cfg_q.unpack_format};
			REG_ADD:    prdata = {30'd0, cfg_q.add_mode};
			REG_WL:     prdata = {26'd0, cfg_q.write_length};
			REG_CL:     prdata = {26'd0, cfg_q.cycle_length};
			REG_UNS:    prdata = {31'd0, cfg_q.unsigned_elements};
			default:    prdata = 32'd0;
		endcase
	end

	vuwe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	vuwe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr),
		.cfg       (cfg_q),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule
